// ===== hw/rtl/tape_machine_executor_top_macros.svh =====
// Assertion helpers for the tape machine executor.
`ifndef TAPE_MACHINE_EXECUTOR_TOP_MACROS_SVH
`define TAPE_MACHINE_EXECUTOR_TOP_MACROS_SVH

// Same-cycle implication, disabled while in reset.
`define TME_ASSERT_IMP(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while in reset.
`define TME_ASSERT_NXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/tme_pkg.sv =====
package tme_pkg;

    localparam int TAPE_CELLS  = 32768;
    localparam int CELL_BITS   = 8;
    localparam int PTR_BITS    = $clog2(TAPE_CELLS);
    localparam int AMOUNT_BITS = 16;
    localparam int BYTE_BITS   = 8;
    localparam int DP_BITS     = 15;
    localparam int SUM_BITS    = PTR_BITS + AMOUNT_BITS + 1;
    localparam int FIFO_DEPTH  = 4;
    localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

    typedef enum logic [2:0] {
        OP_PTR_INC   = 3'd0,
        OP_PTR_DEC   = 3'd1,
        OP_CELL_ADD  = 3'd2,
        OP_CELL_SUB  = 3'd3,
        OP_WRITE     = 3'd4,
        OP_READ      = 3'd5,
        OP_JUMP_FWD  = 3'd6,
        OP_JUMP_BACK = 3'd7
    } tme_op_t;

    typedef struct packed {
        logic                 out_valid;
        logic [BYTE_BITS-1:0] out_byte;
        logic                 branch_taken;
        logic [DP_BITS-1:0]   data_pointer;
        logic [BYTE_BITS-1:0] cell_value;
        logic                 range_error;
    } tme_result_t;

    typedef struct packed {
        logic clearing;
        logic err_flag;
    } tme_status_t;

endpackage

// ===== hw/rtl/tme_in_if.sv =====
interface tme_in_if import tme_pkg::*;;
    logic                   valid;
    logic                   ready;
    logic [2:0]             opcode;
    logic [AMOUNT_BITS-1:0] amount;
    logic [BYTE_BITS-1:0]   in_byte;

    modport source (output valid, output opcode, output amount, output in_byte, input ready);
    modport sink   (input valid, input opcode, input amount, input in_byte, output ready);
endinterface

// ===== hw/rtl/tme_out_if.sv =====
interface tme_out_if import tme_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic                 out_valid;
    logic [BYTE_BITS-1:0] out_byte;
    logic                 branch_taken;
    logic [DP_BITS-1:0]   data_pointer;
    logic [BYTE_BITS-1:0] cell_value;
    logic                 range_error;

    modport source (
        output valid, output out_valid, output out_byte, output branch_taken,
        output data_pointer, output cell_value, output range_error, input ready
    );
    modport sink (
        input valid, input out_valid, input out_byte, input branch_taken,
        input data_pointer, input cell_value, input range_error, output ready
    );
endinterface

// ===== hw/rtl/tme_tape_ram.sv =====
module tme_tape_ram #(
    parameter int DEPTH = 16,
    parameter int WIDTH = 8,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Read returns the old contents when both ports hit the same entry.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== hw/rtl/tme_exec.sv =====
module tme_exec import tme_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    tme_in_if.sink             in_ch,
    input  logic [FIFO_AW:0]   fifo_count,
    output logic               push,
    output tme_result_t        result,
    output tme_status_t        status
);

    logic                 clr_active_reg, clr_active_next;
    logic [PTR_BITS-1:0]  clr_addr_reg, clr_addr_next;
    logic [PTR_BITS-1:0]  ptr_reg, ptr_next;
    logic                 err_reg, err_next;
    logic                 accept;
    logic [FIFO_AW:0]     occupancy;
    tme_op_t              a_op;
    logic [SUM_BITS-1:0]  inc_sum;
    logic                 inc_err;
    logic                 dec_err;

    logic                 b_valid_reg;
    tme_op_t              b_op_reg;
    logic [CELL_BITS-1:0] b_amt_reg;
    logic [BYTE_BITS-1:0] b_byte_reg;
    logic [PTR_BITS-1:0]  b_addr_reg;
    logic                 b_err_reg;

    logic                 fwd_valid_reg;
    logic [PTR_BITS-1:0]  fwd_addr_reg;
    logic [CELL_BITS-1:0] fwd_data_reg;

    logic                 ram_we;
    logic [PTR_BITS-1:0]  ram_waddr;
    logic [CELL_BITS-1:0] ram_wdata;
    logic [CELL_BITS-1:0] ram_rdata;

    logic [CELL_BITS-1:0] cell_old;
    logic [CELL_BITS-1:0] cell_new;
    logic                 b_we;

    // Hold off new items while the tape clear runs, and unless the result queue is sure to have room.
    assign occupancy   = fifo_count + (FIFO_AW + 1)'(b_valid_reg);
    assign in_ch.ready = !clr_active_reg && (occupancy < (FIFO_AW + 1)'(FIFO_DEPTH));
    assign accept      = in_ch.valid && in_ch.ready;
    assign a_op        = tme_op_t'(in_ch.opcode);

    always_comb
    begin
        inc_sum  = SUM_BITS'(ptr_reg) + SUM_BITS'(in_ch.amount);
        inc_err  = inc_sum > SUM_BITS'(TAPE_CELLS - 1);
        dec_err  = SUM_BITS'(in_ch.amount) > SUM_BITS'(ptr_reg);
        ptr_next = ptr_reg;
        err_next = err_reg;
        if (accept)
        begin
            case (a_op)
                OP_PTR_INC:
                begin
                    if (inc_err)
                        err_next = 1'b1;
                    else
                        ptr_next = inc_sum[PTR_BITS-1:0];
                end
                OP_PTR_DEC:
                begin
                    if (dec_err)
                        err_next = 1'b1;
                    else
                        ptr_next = ptr_reg - PTR_BITS'(in_ch.amount);
                end
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_addr_next   = clr_addr_reg;
        if (clr_active_reg)
        begin
            clr_addr_next = clr_addr_reg + PTR_BITS'(1);
            if (clr_addr_reg == PTR_BITS'(TAPE_CELLS - 1))
                clr_active_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_addr_reg   <= '0;
            ptr_reg        <= '0;
            err_reg        <= 1'b0;
            b_valid_reg    <= 1'b0;
            fwd_valid_reg  <= 1'b0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_addr_reg   <= clr_addr_next;
            ptr_reg        <= ptr_next;
            err_reg        <= err_next;
            b_valid_reg    <= accept;
            fwd_valid_reg  <= b_we;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            b_op_reg   <= a_op;
            b_amt_reg  <= CELL_BITS'(in_ch.amount);
            b_byte_reg <= in_ch.in_byte;
            b_addr_reg <= ptr_next;
            b_err_reg  <= err_next;
        end
        fwd_addr_reg <= b_addr_reg;
        fwd_data_reg <= cell_new;
    end

    // Stage B: the read issued last cycle missed a write-back made in that cycle.
    always_comb
    begin
        if (fwd_valid_reg && (fwd_addr_reg == b_addr_reg))
            cell_old = fwd_data_reg;
        else
            cell_old = ram_rdata;

        cell_new = cell_old;
        b_we     = 1'b0;
        case (b_op_reg)
            OP_CELL_ADD:
            begin
                cell_new = cell_old + b_amt_reg;
                b_we     = b_valid_reg;
            end
            OP_CELL_SUB:
            begin
                cell_new = cell_old - b_amt_reg;
                b_we     = b_valid_reg;
            end
            OP_READ:
            begin
                cell_new = CELL_BITS'(b_byte_reg);
                b_we     = b_valid_reg;
            end
            default:
            begin
            end
        endcase

        result.out_valid    = (b_op_reg == OP_WRITE);
        result.out_byte     = (b_op_reg == OP_WRITE) ? cell_old[BYTE_BITS-1:0] : '0;
        case (b_op_reg)
            OP_JUMP_FWD:  result.branch_taken = (cell_old == '0);
            OP_JUMP_BACK: result.branch_taken = (cell_old != '0);
            default:      result.branch_taken = 1'b0;
        endcase
        result.data_pointer = DP_BITS'(b_addr_reg);
        result.cell_value   = cell_new[BYTE_BITS-1:0];
        result.range_error  = b_err_reg;
    end

    assign push = b_valid_reg;

    // The clear sweep owns the write port until it finishes.
    always_comb
    begin
        if (clr_active_reg)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else
        begin
            ram_we    = b_we;
            ram_waddr = b_addr_reg;
            ram_wdata = cell_new;
        end
    end

    tme_tape_ram #(
        .DEPTH (TAPE_CELLS),
        .WIDTH (CELL_BITS),
        .AW    (PTR_BITS)
    ) u_tape (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ptr_next),
        .rdata (ram_rdata)
    );

    assign status.clearing = clr_active_reg;
    assign status.err_flag = err_reg;

endmodule

// ===== hw/rtl/tme_out_fifo.sv =====
module tme_out_fifo import tme_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  tme_result_t      push_data,
    output logic [FIFO_AW:0] count,
    tme_out_if.source        out_ch
);

    tme_result_t          entries [FIFO_DEPTH];
    logic [FIFO_AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [FIFO_AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [FIFO_AW:0]     count_reg, count_next;
    logic                 pop;
    tme_result_t          head;

    assign head         = entries[rd_ptr_reg];
    assign out_ch.valid = (count_reg != '0);
    assign pop          = out_ch.valid && out_ch.ready;
    assign count        = count_reg;

    assign out_ch.out_valid    = head.out_valid;
    assign out_ch.out_byte     = head.out_byte;
    assign out_ch.branch_taken = head.branch_taken;
    assign out_ch.data_pointer = head.data_pointer;
    assign out_ch.cell_value   = head.cell_value;
    assign out_ch.range_error  = head.range_error;

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + FIFO_AW'(1) : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + FIFO_AW'(1) : rd_ptr_reg;
        count_next  = count_reg + (FIFO_AW + 1)'(push) - (FIFO_AW + 1)'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries[wr_ptr_reg] <= push_data;
        end
    end

endmodule

// ===== hw/rtl/tape_machine_executor_top.sv =====
// A result is registered in stage B and offered from the result queue.
// Throughput: one instruction per cycle while no clear runs and the queue has
// room. Each reads one tape cell; add, subtract and read write it back, with
// the write-back forwarded to an immediately following read. Reset clears the
// pointer and error flag at once; it takes no instruction while zeroing tape.
`include "tape_machine_executor_top_macros.svh"

module tape_machine_executor_top import tme_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    tme_in_if.sink    in_ch,
    tme_out_if.source out_ch
);

    logic             push;
    tme_result_t      result;
    tme_status_t      status;
    logic [FIFO_AW:0] fifo_count;

    tme_exec u_exec (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .fifo_count (fifo_count),
        .push       (push),
        .result     (result),
        .status     (status)
    );

    tme_out_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (result),
        .count      (fifo_count),
        .out_ch     (out_ch)
    );

    `TME_ASSERT_IMP(a_no_take_while_clearing, clk, rst_n, in_ch.valid && in_ch.ready, !status.clearing, "instruction taken during tape clear")
    `TME_ASSERT_IMP(a_fifo_no_overflow, clk, rst_n, push && (fifo_count == (FIFO_AW + 1)'(FIFO_DEPTH)), out_ch.ready, "result queue overflow")
    `TME_ASSERT_NXT(a_error_sticky, clk, rst_n, status.err_flag, status.err_flag, "range error flag dropped")
    `TME_ASSERT_NXT(a_result_follows_take, clk, rst_n, in_ch.valid && in_ch.ready, push, "accepted instruction gave no result")

endmodule
